>>> design/ascp_pkg.sv
// shared types, codes and reset values for the two-channel adc scan and probe sequencer
package ascp_pkg;

   // field and register widths
   localparam int unsigned SampleW    = 16;
   localparam int unsigned LevelW     = 16;
   localparam int unsigned IntervalW  = 16;
   localparam int unsigned SettleW    = 10;
   localparam int unsigned RetryW     = 16;
   localparam int unsigned DeltaW     = 16;
   localparam int unsigned GainW      = 18;
   localparam int unsigned KindW      = 2;
   localparam int unsigned DriveW     = 2;
   localparam int unsigned CsrIndexW  = 3;
   localparam int unsigned CsrDataW   = 18;

   // event kinds on the request channel
   localparam logic [KindW-1:0] KIND_TICK   = 2'd0;
   localparam logic [KindW-1:0] KIND_RESULT = 2'd1;
   localparam logic [KindW-1:0] KIND_FAULT  = 2'd2;
   localparam logic [KindW-1:0] KIND_ONLINE = 2'd3;

   // probe pin codes
   localparam logic [DriveW-1:0] DRIVE_HIZ  = 2'd0;
   localparam logic [DriveW-1:0] DRIVE_HIGH = 2'd1;
   localparam logic [DriveW-1:0] DRIVE_LOW  = 2'd2;

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_PROBE_INTERVAL = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_SETTLE         = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_RETRY          = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_OPEN_DELTA     = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_LEVEL_GAIN     = 3'd4;

   // register reset values
   localparam logic [IntervalW-1:0] RESET_PROBE_INTERVAL = 16'd250;
   localparam logic [SettleW-1:0]   RESET_SETTLE         = 10'd20;
   localparam logic [RetryW-1:0]    RESET_RETRY          = 16'd1000;
   localparam logic [DeltaW-1:0]    RESET_OPEN_DELTA     = 16'd6400;
   localparam logic [GainW-1:0]     RESET_LEVEL_GAIN     = 18'd162686;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_CH0_WAIT,
      PH_CH1_WAIT,
      PH_HIGH_SETTLE,
      PH_HIGH_WAIT,
      PH_LOW_SETTLE,
      PH_LOW_WAIT
   } phase_type;

   typedef struct packed {
      logic [IntervalW-1:0] probe_interval;
      logic [SettleW-1:0]   settle;
      logic [RetryW-1:0]    retry;
      logic [DeltaW-1:0]    open_delta;
      logic [GainW-1:0]     level_gain;
   } cfg_type;

   typedef struct packed {
      logic              start_conversion;
      logic              conversion_channel;
      logic [DriveW-1:0] probe_drive;
      logic              begin_request;
      logic              adc_online;
      logic [LevelW-1:0] level_first;
      logic [LevelW-1:0] level_second;
      logic              connected_first;
      logic              connected_second;
   } rsp_payload_type;

endpackage

>>> design/ascp_if.sv
// request and result channel interfaces

interface ascp_req_if;
   import ascp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KindW-1:0]          kind;
   logic signed [SampleW-1:0] sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface ascp_rsp_if;
   import ascp_pkg::*;

   logic              valid;
   logic              ready;
   logic              start_conversion;
   logic              conversion_channel;
   logic [DriveW-1:0] probe_drive;
   logic              begin_request;
   logic              adc_online;
   logic [LevelW-1:0] level_first;
   logic [LevelW-1:0] level_second;
   logic              connected_first;
   logic              connected_second;

   modport source (
      output valid, output start_conversion, output conversion_channel, output probe_drive,
      output begin_request, output adc_online, output level_first, output level_second,
      output connected_first, output connected_second, input ready
   );
   modport sink (
      input valid, input start_conversion, input conversion_channel, input probe_drive,
      input begin_request, input adc_online, input level_first, input level_second,
      input connected_first, input connected_second, output ready
   );
endinterface

>>> design/ascp_level.sv
// sample to level conversion: clamp negatives, q16 gain, saturate to 16 bits
module ascp_level (
   input  logic signed [ascp_pkg::SampleW-1:0] sample,
   input  logic [ascp_pkg::GainW-1:0]          gain,
   output logic [ascp_pkg::LevelW-1:0]         level
);
   import ascp_pkg::*;

   localparam int unsigned PosW  = SampleW - 1;
   localparam int unsigned ProdW = PosW + GainW;
   localparam int unsigned Frac  = 16;

   logic [PosW-1:0]         pos;
   logic [ProdW-1:0]        product;
   logic [ProdW-Frac-1:0]   scaled;

   // negative samples read as zero
   assign pos = sample[SampleW-1] ? '0 : sample[PosW-1:0];

   assign product = ProdW'(pos) * ProdW'(gain);
   assign scaled  = product[ProdW-1:Frac];

   // saturate at full scale
   assign level = (|scaled[ProdW-Frac-1:LevelW]) ? {LevelW{1'b1}} : scaled[LevelW-1:0];

endmodule

>>> design/ascp_seq.sv
// scan and probe sequencer state with its per-event update
module ascp_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [ascp_pkg::KindW-1:0]          kind,
   input  logic signed [ascp_pkg::SampleW-1:0] sample,
   input  logic [ascp_pkg::LevelW-1:0]         level,
   input  ascp_pkg::cfg_type                   cfg,
   output ascp_pkg::rsp_payload_type           result
);
   import ascp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  online_ff, online_in;
   logic                  target_ff, target_in;
   logic [IntervalW-1:0]  probe_cnt_ff, probe_cnt_in;
   logic [SettleW-1:0]    settle_cnt_ff, settle_cnt_in;
   logic [RetryW-1:0]     retry_cnt_ff, retry_cnt_in;
   logic [SampleW-1:0]    high_sample_ff, high_sample_in;
   logic [LevelW-1:0]     level0_ff, level0_in;
   logic [LevelW-1:0]     level1_ff, level1_in;
   logic [1:0]            conn_ff, conn_in;
   logic [DriveW-1:0]     pin_ff, pin_in;

   logic                  settling;
   logic                  settle_done;
   logic signed [SampleW:0] diff;
   logic [SampleW:0]      abs_diff;
   logic                  is_connected;
   logic                  start;
   logic                  chan;
   logic                  begin_req;

   assign settling    = (phase_ff == PH_HIGH_SETTLE) || (phase_ff == PH_LOW_SETTLE);
   assign settle_done = (settle_cnt_ff <= SettleW'(1));

   // open-input judgement from the high and low samples
   assign diff         = {high_sample_ff[SampleW-1], high_sample_ff} - {sample[SampleW-1], sample};
   assign abs_diff     = diff[SampleW] ? (SampleW+1)'(-diff) : diff;
   assign is_connected = abs_diff < {1'b0, cfg.open_delta};

   // next state
   always_comb begin
      phase_in       = phase_ff;
      online_in      = online_ff;
      target_in      = target_ff;
      probe_cnt_in   = probe_cnt_ff;
      settle_cnt_in  = settle_cnt_ff;
      retry_cnt_in   = retry_cnt_ff;
      high_sample_in = high_sample_ff;
      level0_in      = level0_ff;
      level1_in      = level1_ff;
      conn_in        = conn_ff;
      pin_in         = pin_ff;
      case (kind)
         KIND_TICK: begin
            if (!online_ff) begin
               if (retry_cnt_ff <= RetryW'(1)) begin
                  retry_cnt_in = cfg.retry;
               end else begin
                  retry_cnt_in = retry_cnt_ff - RetryW'(1);
               end
            end else begin
               if (probe_cnt_ff != '0) begin
                  probe_cnt_in = probe_cnt_ff - IntervalW'(1);
               end
               if (settling) begin
                  if (settle_done) begin
                     settle_cnt_in = '0;
                     phase_in = (phase_ff == PH_HIGH_SETTLE) ? PH_HIGH_WAIT : PH_LOW_WAIT;
                  end else begin
                     settle_cnt_in = settle_cnt_ff - SettleW'(1);
                  end
               end
            end
         end
         KIND_RESULT: begin
            if (online_ff) begin
               case (phase_ff)
                  PH_CH0_WAIT: begin
                     level0_in = level;
                     phase_in  = PH_CH1_WAIT;
                  end
                  PH_CH1_WAIT: begin
                     level1_in = level;
                     if (probe_cnt_ff == '0) begin
                        pin_in        = DRIVE_HIGH;
                        settle_cnt_in = cfg.settle;
                        phase_in      = PH_HIGH_SETTLE;
                     end else begin
                        phase_in = PH_CH0_WAIT;
                     end
                  end
                  PH_HIGH_WAIT: begin
                     high_sample_in = sample;
                     pin_in         = DRIVE_LOW;
                     settle_cnt_in  = cfg.settle;
                     phase_in       = PH_LOW_SETTLE;
                  end
                  PH_LOW_WAIT: begin
                     pin_in             = DRIVE_HIZ;
                     conn_in[target_ff] = is_connected;
                     target_in          = ~target_ff;
                     probe_cnt_in       = cfg.probe_interval;
                     phase_in           = PH_CH0_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         KIND_FAULT: begin
            pin_in        = DRIVE_HIZ;
            online_in     = 1'b0;
            conn_in       = '0;
            phase_in      = PH_CH0_WAIT;
            settle_cnt_in = '0;
            retry_cnt_in  = cfg.retry;
         end
         default: begin
            // adc came online, or re-initialised while online
            online_in     = 1'b1;
            conn_in       = '0;
            probe_cnt_in  = cfg.probe_interval;
            target_in     = 1'b0;
            pin_in        = DRIVE_HIZ;
            settle_cnt_in = '0;
            phase_in      = PH_CH0_WAIT;
         end
      endcase
   end

   // result fields
   always_comb begin
      start     = 1'b0;
      chan      = 1'b0;
      begin_req = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (!online_ff) begin
               begin_req = (retry_cnt_ff <= RetryW'(1));
            end else if (settling && settle_done) begin
               start = 1'b1;
               chan  = target_ff;
            end
         end
         KIND_RESULT: begin
            if (online_ff) begin
               case (phase_ff)
                  PH_CH0_WAIT: begin
                     start = 1'b1;
                     chan  = 1'b1;
                  end
                  PH_CH1_WAIT: start = (probe_cnt_ff != '0);
                  PH_LOW_WAIT: start = 1'b1;
                  default: begin
                  end
               endcase
            end
         end
         KIND_ONLINE: start = 1'b1;
         default: begin
         end
      endcase
      result.start_conversion   = start;
      result.conversion_channel = chan;
      result.probe_drive        = pin_in;
      result.begin_request      = begin_req;
      result.adc_online         = online_in;
      result.level_first        = level0_in;
      result.level_second       = level1_in;
      result.connected_first    = conn_in[0] & online_in;
      result.connected_second   = conn_in[1] & online_in;
   end

   // state registers, updated once per event
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_CH0_WAIT;
         online_ff      <= 1'b0;
         target_ff      <= 1'b0;
         probe_cnt_ff   <= '0;
         settle_cnt_ff  <= '0;
         retry_cnt_ff   <= '0;
         high_sample_ff <= '0;
         level0_ff      <= '0;
         level1_ff      <= '0;
         conn_ff        <= '0;
         pin_ff         <= DRIVE_HIZ;
      end else if (step) begin
         phase_ff       <= phase_in;
         online_ff      <= online_in;
         target_ff      <= target_in;
         probe_cnt_ff   <= probe_cnt_in;
         settle_cnt_ff  <= settle_cnt_in;
         retry_cnt_ff   <= retry_cnt_in;
         high_sample_ff <= high_sample_in;
         level0_ff      <= level0_in;
         level1_ff      <= level1_in;
         conn_ff        <= conn_in;
         pin_ff         <= pin_in;
      end
   end

endmodule

>>> design/two_channel_adc_scan_open_probe_core.sv
// top level of the two-channel adc scan and open-input probe sequencer
//
// Events arrive on the req channel: millisecond ticks, conversion results
// (signed sample), bus faults and adc-online notices. Every event gives exactly
// one result on the rsp channel: conversion request and channel, probe pin
// drive, reconnect request, online flag, both channel levels and both
// connected flags as they stand after the event.
// Each accepted event is held in an input register, updated against the
// sequencer state combinationally and the result lands in an output register,
// from which it is offered on rsp. One event per cycle is sustained while the
// receiver keeps rsp ready high; the sequencer state loop goes through the
// sequencer state registers only.
// The csr port writes the five settings (probe interval, settle time, retry
// period, open threshold, level gain) by index; write them only while idle.
// Synchronous reset loads the default settings, clears both levels and flags,
// puts the pin at high impedance and leaves the block offline, so the first
// tick asks for a reconnect. When the receiver stalls, the output register
// holds its result and the input register takes one more event before
// req ready drops.
module two_channel_adc_scan_open_probe_core (
   input  logic                              clock,
   input  logic                              reset,
   ascp_req_if.sink                          req_ch,
   ascp_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [ascp_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [ascp_pkg::CsrDataW-1:0]     csr_wdata
);
   import ascp_pkg::*;

   cfg_type                   cfg_ff;
   logic                      in_vld_ff;
   logic [KindW-1:0]          in_kind_ff;
   logic signed [SampleW-1:0] in_sample_ff;
   logic                      out_vld_ff;
   rsp_payload_type           out_ff;
   rsp_payload_type           result;
   logic [LevelW-1:0]         level;
   logic                      advance;
   logic                      req_fire;

   // the held event moves on when the output register is free or draining
   assign advance  = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_vld_ff || advance;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.probe_interval <= RESET_PROBE_INTERVAL;
         cfg_ff.settle         <= RESET_SETTLE;
         cfg_ff.retry          <= RESET_RETRY;
         cfg_ff.open_delta     <= RESET_OPEN_DELTA;
         cfg_ff.level_gain     <= RESET_LEVEL_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROBE_INTERVAL: cfg_ff.probe_interval <= csr_wdata[IntervalW-1:0];
            CSR_SETTLE:         cfg_ff.settle         <= csr_wdata[SettleW-1:0];
            CSR_RETRY:          cfg_ff.retry          <= csr_wdata[RetryW-1:0];
            CSR_OPEN_DELTA:     cfg_ff.open_delta     <= csr_wdata[DeltaW-1:0];
            CSR_LEVEL_GAIN:     cfg_ff.level_gain     <= csr_wdata[GainW-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_ch.kind;
         in_sample_ff <= req_ch.sample;
      end
   end

   ascp_level u_level (
      .sample (in_sample_ff),
      .gain   (cfg_ff.level_gain),
      .level  (level)
   );

   ascp_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .kind   (in_kind_ff),
      .sample (in_sample_ff),
      .level  (level),
      .cfg    (cfg_ff),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid              = out_vld_ff;
   assign rsp_ch.start_conversion   = out_ff.start_conversion;
   assign rsp_ch.conversion_channel = out_ff.conversion_channel;
   assign rsp_ch.probe_drive        = out_ff.probe_drive;
   assign rsp_ch.begin_request      = out_ff.begin_request;
   assign rsp_ch.adc_online         = out_ff.adc_online;
   assign rsp_ch.level_first        = out_ff.level_first;
   assign rsp_ch.level_second       = out_ff.level_second;
   assign rsp_ch.connected_first    = out_ff.connected_first;
   assign rsp_ch.connected_second   = out_ff.connected_second;

endmodule

>>> tb/tb_two_channel_adc_scan_open_probe_core.sv
// self-checking testbench for the two-channel adc scan and open-input probe sequencer
`timescale 1ns / 1ps

module tb_two_channel_adc_scan_open_probe_core;
   import ascp_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 6;
   localparam int PRINT_LIMIT     = 100;
   localparam logic [GainW-1:0] GAIN_FULL = '1;

   typedef struct packed {
      logic [KindW-1:0]          kind;
      logic signed [SampleW-1:0] sample;
   } scan_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CsrIndexW-1:0] csr_index = CSR_PROBE_INTERVAL;
   logic [CsrDataW-1:0]  csr_wdata = '0;

   ascp_req_if req_ch ();
   ascp_rsp_if rsp_ch ();

   two_channel_adc_scan_open_probe_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // settings as the block should hold them
   logic [IntervalW-1:0] set_probe  = RESET_PROBE_INTERVAL;
   logic [SettleW-1:0]   set_settle = RESET_SETTLE;
   logic [RetryW-1:0]    set_retry  = RESET_RETRY;
   logic [DeltaW-1:0]    set_delta  = RESET_OPEN_DELTA;
   logic [GainW-1:0]     set_gain   = RESET_LEVEL_GAIN;

   // sequencer state as predicted
   phase_type                 seq_phase     = PH_CH0_WAIT;
   logic                      seq_online    = 1'b0;
   logic                      seq_target    = 1'b0;
   logic [IntervalW-1:0]      seq_probe_cd  = '0;
   logic [SettleW-1:0]        seq_settle_cd = '0;
   logic [RetryW-1:0]         seq_retry_cd  = '0;
   logic signed [SampleW-1:0] seq_high_sample = '0;
   logic [DriveW-1:0]         seq_pin       = DRIVE_HIZ;
   logic [LevelW-1:0]         seq_level [2] = '{16'd0, 16'd0};
   logic                      seq_connected [2] = '{1'b0, 1'b0};

   scan_event_type  event_q [$];
   rsp_payload_type expected_status_q [$];

   int mismatch_count = 0;
   int queued_total   = 0;
   int result_count   = 0;
   int quiet_cycles   = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int hold_off_token = 0;
   int hold_off_seen  = 0;
   int hold_off_left  = 0;
   int pattern_age    = 0;
   logic sender_hold  = 1'b0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic signed [SampleW-1:0] last_sample = '0;
   scan_event_type  next_event;
   rsp_payload_type want;
   logic offer;

   // counts to level: max(sample,0) * gain >> 16, saturated
   function automatic logic [LevelW-1:0] level_of(input logic signed [SampleW-1:0] sample);
      logic [63:0] prod;
      if (sample <= 0) return '0;
      prod = ({48'd0, sample} * {46'd0, set_gain}) >> 16;
      return (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
   endfunction

   // one event through the predicted sequencer, expected status queued
   task automatic advance_sequencer(input logic [KindW-1:0] kind,
                                    input logic signed [SampleW-1:0] sample);
      rsp_payload_type status;
      logic start, chan, begin_req;
      int gap, spread;
      start = 1'b0;
      chan = 1'b0;
      begin_req = 1'b0;
      case (kind)
         KIND_TICK: begin
            if (!seq_online) begin
               // reconnect request when the retry period runs out
               if (seq_retry_cd <= 1) begin
                  begin_req = 1'b1;
                  seq_retry_cd = set_retry;
               end else seq_retry_cd = seq_retry_cd - 1'b1;
            end else begin
               if (seq_probe_cd != 0) seq_probe_cd = seq_probe_cd - 1'b1;
               if (seq_phase == PH_HIGH_SETTLE || seq_phase == PH_LOW_SETTLE) begin
                  if (seq_settle_cd <= 1) begin
                     seq_settle_cd = '0;
                     start = 1'b1;
                     chan = seq_target;
                     seq_phase = (seq_phase == PH_HIGH_SETTLE) ? PH_HIGH_WAIT : PH_LOW_WAIT;
                  end else seq_settle_cd = seq_settle_cd - 1'b1;
               end
            end
         end
         KIND_RESULT: begin
            if (seq_online) begin
               case (seq_phase)
                  PH_CH0_WAIT: begin
                     seq_level[0] = level_of(sample);
                     start = 1'b1;
                     chan = 1'b1;
                     seq_phase = PH_CH1_WAIT;
                  end
                  PH_CH1_WAIT: begin
                     seq_level[1] = level_of(sample);
                     if (seq_probe_cd == 0) begin
                        seq_pin = DRIVE_HIGH;
                        seq_settle_cd = set_settle;
                        seq_phase = PH_HIGH_SETTLE;
                     end else begin
                        start = 1'b1;
                        seq_phase = PH_CH0_WAIT;
                     end
                  end
                  PH_HIGH_WAIT: begin
                     seq_high_sample = sample;
                     seq_pin = DRIVE_LOW;
                     seq_settle_cd = set_settle;
                     seq_phase = PH_LOW_SETTLE;
                  end
                  PH_LOW_WAIT: begin
                     // open when the two probe samples differ too much
                     gap = int'(seq_high_sample) - int'(sample);
                     spread = (gap < 0) ? -gap : gap;
                     seq_pin = DRIVE_HIZ;
                     seq_connected[seq_target] = (spread < int'(set_delta));
                     seq_target = ~seq_target;
                     seq_probe_cd = set_probe;
                     start = 1'b1;
                     seq_phase = PH_CH0_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         KIND_FAULT: begin
            seq_pin = DRIVE_HIZ;
            seq_online = 1'b0;
            seq_connected[0] = 1'b0;
            seq_connected[1] = 1'b0;
            seq_phase = PH_CH0_WAIT;
            seq_settle_cd = '0;
            seq_retry_cd = set_retry;
         end
         default: begin
            seq_online = 1'b1;
            seq_connected[0] = 1'b0;
            seq_connected[1] = 1'b0;
            seq_probe_cd = set_probe;
            seq_target = 1'b0;
            seq_pin = DRIVE_HIZ;
            seq_settle_cd = '0;
            seq_phase = PH_CH0_WAIT;
            start = 1'b1;
         end
      endcase
      status.start_conversion   = start;
      status.conversion_channel = start & chan;
      status.probe_drive        = seq_pin;
      status.begin_request      = begin_req;
      status.adc_online         = seq_online;
      status.level_first        = seq_level[0];
      status.level_second       = seq_level[1];
      status.connected_first    = seq_connected[0] & seq_online;
      status.connected_second   = seq_connected[1] & seq_online;
      expected_status_q.push_back(status);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: result %0d %s: got %0h, expected %0h",
                  $time, result_count, what, got, exp_val);
   endtask

   // sender: bursts of random length, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else if (!(req_ch.valid && !req_ch.ready)) begin
         if (req_ch.valid) advance_sequencer(req_ch.kind, req_ch.sample);
         offer = 1'b0;
         if (gap_left > 0) gap_left--;
         else if (!sender_hold && event_q.size() != 0) begin
            next_event = event_q.pop_front();
            offer = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.kind <= next_event.kind;
            req_ch.sample <= next_event.sample;
         end
      end
   end

   // receiver: check each transfer, then stall on a rotating pattern
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b1;
      else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            if (expected_status_q.size() == 0)
               report_mismatch("result with nothing expected", 32'd1, 32'd0);
            else begin
               want = expected_status_q.pop_front();
               if (rsp_ch.start_conversion !== want.start_conversion)
                  report_mismatch("start_conversion", rsp_ch.start_conversion,
                                  want.start_conversion);
               if (rsp_ch.conversion_channel !== want.conversion_channel)
                  report_mismatch("conversion_channel", rsp_ch.conversion_channel,
                                  want.conversion_channel);
               if (rsp_ch.probe_drive !== want.probe_drive)
                  report_mismatch("probe_drive", rsp_ch.probe_drive, want.probe_drive);
               if (rsp_ch.begin_request !== want.begin_request)
                  report_mismatch("begin_request", rsp_ch.begin_request, want.begin_request);
               if (rsp_ch.adc_online !== want.adc_online)
                  report_mismatch("adc_online", rsp_ch.adc_online, want.adc_online);
               if (rsp_ch.level_first !== want.level_first)
                  report_mismatch("level_first", rsp_ch.level_first, want.level_first);
               if (rsp_ch.level_second !== want.level_second)
                  report_mismatch("level_second", rsp_ch.level_second, want.level_second);
               if (rsp_ch.connected_first !== want.connected_first)
                  report_mismatch("connected_first", rsp_ch.connected_first,
                                  want.connected_first);
               if (rsp_ch.connected_second !== want.connected_second)
                  report_mismatch("connected_second", rsp_ch.connected_second,
                                  want.connected_second);
            end
         end
         // long hold-off on request, counted here
         if (hold_off_token != hold_off_seen) begin
            hold_off_seen = hold_off_token;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age >= 97) begin
               pattern_age = 0;
               stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                           : (16'($urandom) | 16'h0001);
            end
            rsp_ch.ready <= stall_pattern[0];
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   task automatic push_event(input logic [KindW-1:0] kind,
                             input logic signed [SampleW-1:0] sample);
      scan_event_type ev;
      ev.kind = kind;
      ev.sample = sample;
      event_q.push_back(ev);
      queued_total++;
   endtask

   // samples: extremes, near the last one (probe pairs that match) or anywhere
   function automatic logic signed [SampleW-1:0] pick_sample();
      logic signed [SampleW-1:0] v;
      int span;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               default: v = 16'hFFFF;
            endcase
         end
         1, 2, 3: begin
            span = ($urandom_range(0, 1) == 0) ? 200 : 8000;
            v = last_sample + 16'($urandom_range(0, 2 * span)) - 16'(span);
         end
         default: v = 16'($urandom);
      endcase
      last_sample = v;
      return v;
   endfunction

   // mostly well-formed scans with ticks between results, some noise and faults
   task automatic queue_traffic(input int count);
      int goal, roll, ticks;
      goal = queued_total + count;
      if ($urandom_range(0, 3) != 0) push_event(KIND_ONLINE, 16'($urandom));
      while (queued_total < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            repeat ($urandom_range(1, 8)) begin
               ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
               repeat (ticks) push_event(KIND_TICK, 16'($urandom));
               push_event(KIND_RESULT, pick_sample());
            end
         end else if (roll < 88) begin
            repeat ($urandom_range(1, 3)) push_event(2'($urandom), 16'($urandom));
         end else if (roll < 94) push_event(KIND_ONLINE, 16'($urandom));
         else begin
            push_event(KIND_FAULT, 16'($urandom));
            repeat ($urandom_range(0, 14)) push_event(KIND_TICK, 16'($urandom));
            push_event(KIND_ONLINE, 16'($urandom));
         end
      end
   endtask

   task automatic write_setting(input logic [CsrIndexW-1:0] index,
                                input logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_PROBE_INTERVAL: set_probe = value[IntervalW-1:0];
         CSR_SETTLE:         set_settle = value[SettleW-1:0];
         CSR_RETRY:          set_retry = value[RetryW-1:0];
         CSR_OPEN_DELTA:     set_delta = value[DeltaW-1:0];
         default:            set_gain = value[GainW-1:0];
      endcase
   endtask

   task automatic apply_settings(input logic [IntervalW-1:0] interval,
                                 input logic [SettleW-1:0] settle,
                                 input logic [RetryW-1:0] retry,
                                 input logic [DeltaW-1:0] delta,
                                 input logic [GainW-1:0] gain);
      write_setting(CSR_PROBE_INTERVAL, interval);
      write_setting(CSR_SETTLE, settle);
      write_setting(CSR_RETRY, retry);
      write_setting(CSR_OPEN_DELTA, delta);
      write_setting(CSR_LEVEL_GAIN, gain);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every queued event sent and every expected status back, then a short drain
   task automatic wait_idle();
      while (event_q.size() != 0 || req_ch.valid || expected_status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic pause_sender();
      sender_hold <= 1'b1;
      @(posedge clock);
      while (req_ch.valid || expected_status_q.size() != 0) @(posedge clock);
      sender_hold <= 1'b0;
   endtask

   task automatic random_settings();
      logic [DeltaW-1:0] delta;
      logic [GainW-1:0]  gain;
      case ($urandom_range(0, 3))
         0: delta = '0;
         1: delta = '1;
         default: delta = 16'($urandom_range(1, 12000));
      endcase
      case ($urandom_range(0, 3))
         0: gain = '0;
         1: gain = GAIN_FULL;
         default: gain = 18'($urandom_range(0, 262143));
      endcase
      apply_settings(16'($urandom_range(0, 12)), 10'($urandom_range(0, 5)),
                     16'($urandom_range(0, 12)), delta, gain);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.sample = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: offline ticks, ignored result, faults, scan extremes
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_TICK, 16'hFFFF);
      push_event(KIND_RESULT, 16'd1234);
      push_event(KIND_FAULT, 16'h0000);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_ONLINE, 16'h0000);
      push_event(KIND_RESULT, 16'h7FFF);
      push_event(KIND_RESULT, 16'h8000);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_RESULT, 16'h0000);
      push_event(KIND_RESULT, 16'hFFFF);
      push_event(KIND_ONLINE, 16'h0000);
      push_event(KIND_FAULT, 16'h0000);
      wait_idle();

      // zero settings, full gain: probe on every scan, ignored result while settling
      apply_settings('0, '0, '0, '0, GAIN_FULL);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_ONLINE, 16'h0000);
      push_event(KIND_RESULT, 16'h7FFF);
      push_event(KIND_RESULT, 16'd1);
      push_event(KIND_RESULT, 16'd500);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_RESULT, 16'd500);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_RESULT, 16'd500);
      push_event(KIND_RESULT, 16'h8000);
      push_event(KIND_RESULT, 16'd100);
      push_event(KIND_FAULT, 16'h0000);
      push_event(KIND_TICK, 16'h0000);
      push_event(KIND_TICK, 16'h0000);
      wait_idle();

      // random scans under small settings
      apply_settings(16'd3, 10'd1, 16'd2, RESET_OPEN_DELTA, RESET_LEVEL_GAIN);
      queue_traffic(110);
      wait_idle();
      for (int round = 0; round < 6; round++) begin
         random_settings();
         if (round == 3) begin
            // sender pause mid-phase until all results are back
            queue_traffic(50);
            while (event_q.size() > 25) @(posedge clock);
            pause_sender();
            queue_traffic(50);
         end else begin
            queue_traffic(100);
            // receiver holds off while the sender keeps offering
            if (round == 1) hold_off_token <= hold_off_token + 1;
         end
         wait_idle();
      end

      // largest settings
      apply_settings('1, '1, '1, '1, GAIN_FULL);
      queue_traffic(40);
      wait_idle();

      // back to the reset values
      apply_settings(RESET_PROBE_INTERVAL, RESET_SETTLE, RESET_RETRY, RESET_OPEN_DELTA,
                     RESET_LEVEL_GAIN);
      queue_traffic(60);
      wait_idle();

      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

>>> two_channel_adc_scan_open_probe_core.f
design/ascp_pkg.sv
design/ascp_if.sv
design/ascp_level.sv
design/ascp_seq.sv
design/two_channel_adc_scan_open_probe_core.sv
tb/tb_two_channel_adc_scan_open_probe_core.sv
